// File: hw/rtl/aoc_pkg.sv
// ============================================================================
// aoc_pkg: shared types and constants for the alpha over compositor
// Widths of the pixel fields, the divider lane format and alpha codes.
// ============================================================================
`default_nettype none

package aoc_pkg;

  // Pixel field widths
  localparam int unsigned CH_W  = 8;
  // Numerator is at most 255 * den, den at most 255 * 255
  localparam int unsigned NUM_W = 24;
  localparam int unsigned DEN_W = 16;
  // Quotient width, one divider stage per bit
  localparam int unsigned Q_W   = 8;
  // Three colour lanes plus the alpha lane
  localparam int unsigned LANES = 4;
  localparam int unsigned ALPHA_LANE = 3;

  // Alpha codes that select a pass-through
  localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'd0;
  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;

  // Divisor of the alpha lane, and the unit divisor for pass-through lanes
  localparam logic [DEN_W-1:0] ALPHA_DIV = 16'd255;
  localparam logic [DEN_W-1:0] UNIT_DIV  = 16'd1;

  // One divider lane: running remainder, divisor and partial quotient
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] dvs;
    logic [Q_W-1:0]   quo;
  } lane_t;

  typedef lane_t [LANES-1:0] lane_vec_t;

  // What travels from one pipeline stage to the next
  typedef struct packed {
    logic      vld;
    logic      last;
    lane_vec_t lanes;
  } stage_t;

endpackage

`default_nettype wire

// File: hw/rtl/aoc_front.sv
// ============================================================================
// aoc_front: product stages of the compositor
// Forms the products, the blend denominator and the divider lanes over two
// register stages.
// ============================================================================
`default_nettype none

module aoc_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     vld_in,
  input  wire logic                     last_in,
  input  wire logic [aoc_pkg::CH_W-1:0] base_c  [3],
  input  wire logic [aoc_pkg::CH_W-1:0] base_a,
  input  wire logic [aoc_pkg::CH_W-1:0] draw_c  [3],
  input  wire logic [aoc_pkg::CH_W-1:0] draw_a,
  output aoc_pkg::stage_t               stg_out
);

  localparam int unsigned PW = 2 * aoc_pkg::CH_W;

  // Stage 1 registers
  logic                     vld1_r;
  logic                     last1_r;
  logic [aoc_pkg::CH_W-1:0] b1_r  [3];
  logic [aoc_pkg::CH_W-1:0] d1_r  [3];
  logic [aoc_pkg::CH_W-1:0] ba1_r;
  logic [aoc_pkg::CH_W-1:0] da1_r;
  logic [aoc_pkg::CH_W-1:0] wa1_r;
  logic [PW-1:0]            pd1_r [3];
  logic [PW-1:0]            pb1_r [3];
  logic [aoc_pkg::DEN_W-1:0] den1_r;

  logic [aoc_pkg::CH_W-1:0]  wa_nxt;
  logic [PW-1:0]             bw_nxt;
  logic [PW-1:0]             pd_nxt [3];
  logic [PW-1:0]             pb_nxt [3];
  logic [aoc_pkg::DEN_W:0]   den_wide;
  logic [aoc_pkg::DEN_W-1:0] den_nxt;

  // Stage 2 registers
  aoc_pkg::stage_t          stg2_r;
  aoc_pkg::lane_vec_t       lanes_nxt;
  logic [aoc_pkg::NUM_W-1:0] pbw_nxt [3];
  logic [aoc_pkg::NUM_W-1:0] num_nxt [3];

  // Form per-channel products and the denominator 255*da + ba*(255-da)
  always_comb begin
    wa_nxt   = aoc_pkg::ALPHA_OPAQUE - draw_a;
    bw_nxt   = {8'b0, base_a} * {8'b0, wa_nxt};
    den_wide = ({1'b0, draw_a, 8'b0} - {9'b0, draw_a}) + {1'b0, bw_nxt};
    den_nxt  = den_wide[aoc_pkg::DEN_W-1:0];
    for (int i = 0; i < 3; i++) begin
      pd_nxt[i] = {8'b0, draw_c[i]} * {8'b0, draw_a};
      pb_nxt[i] = {8'b0, base_c[i]} * {8'b0, base_a};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    last1_r <= last_in;
    ba1_r   <= base_a;
    da1_r   <= draw_a;
    wa1_r   <= wa_nxt;
    den1_r  <= den_nxt;
    for (int i = 0; i < 3; i++) begin
      b1_r[i]  <= base_c[i];
      d1_r[i]  <= draw_c[i];
      pd1_r[i] <= pd_nxt[i];
      pb1_r[i] <= pb_nxt[i];
    end
  end

  // Build the numerators and pick the lanes; pass-through lanes divide by one
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pbw_nxt[i] = {8'b0, pb1_r[i]} * {16'b0, wa1_r};
      num_nxt[i] = ({pd1_r[i], 8'b0} - {8'b0, pd1_r[i]}) + pbw_nxt[i];
    end
    for (int i = 0; i < aoc_pkg::LANES; i++) begin
      lanes_nxt[i].quo = '0;
    end
    if (da1_r == aoc_pkg::ALPHA_CLEAR) begin
      for (int i = 0; i < 3; i++) begin
        lanes_nxt[i].rem = {16'b0, b1_r[i]};
        lanes_nxt[i].dvs = aoc_pkg::UNIT_DIV;
      end
      lanes_nxt[aoc_pkg::ALPHA_LANE].rem = {16'b0, ba1_r};
      lanes_nxt[aoc_pkg::ALPHA_LANE].dvs = aoc_pkg::UNIT_DIV;
    end else if (da1_r == aoc_pkg::ALPHA_OPAQUE) begin
      for (int i = 0; i < 3; i++) begin
        lanes_nxt[i].rem = {16'b0, d1_r[i]};
        lanes_nxt[i].dvs = aoc_pkg::UNIT_DIV;
      end
      lanes_nxt[aoc_pkg::ALPHA_LANE].rem = {16'b0, da1_r};
      lanes_nxt[aoc_pkg::ALPHA_LANE].dvs = aoc_pkg::UNIT_DIV;
    end else begin
      for (int i = 0; i < 3; i++) begin
        lanes_nxt[i].rem = num_nxt[i];
        lanes_nxt[i].dvs = den1_r;
      end
      lanes_nxt[aoc_pkg::ALPHA_LANE].rem = {8'b0, den1_r};
      lanes_nxt[aoc_pkg::ALPHA_LANE].dvs = aoc_pkg::ALPHA_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg2_r.vld <= 1'b0;
    end else begin
      stg2_r.vld <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    stg2_r.last  <= last1_r;
    stg2_r.lanes <= lanes_nxt;
  end

  assign stg_out = stg2_r;

endmodule

`default_nettype wire

// File: hw/rtl/aoc_div_stage.sv
// ============================================================================
// aoc_div_stage: one restoring division step
// Resolves one quotient bit in every lane and registers the result.
// ============================================================================
`default_nettype none

module aoc_div_stage #(
  parameter int unsigned BIT_IDX = aoc_pkg::Q_W - 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire aoc_pkg::stage_t stg_in,
  output aoc_pkg::stage_t      stg_out
);

  aoc_pkg::stage_t           stg_r;
  aoc_pkg::lane_vec_t        lanes_nxt;
  logic [aoc_pkg::NUM_W-1:0] shifted [aoc_pkg::LANES];

  // Subtract the shifted divisor where it fits and set the quotient bit
  always_comb begin
    for (int i = 0; i < aoc_pkg::LANES; i++) begin
      lanes_nxt[i] = stg_in.lanes[i];
      shifted[i]   = {{(aoc_pkg::NUM_W - aoc_pkg::DEN_W){1'b0}}, stg_in.lanes[i].dvs}
                     << BIT_IDX;
      if (stg_in.lanes[i].rem >= shifted[i]) begin
        lanes_nxt[i].rem          = stg_in.lanes[i].rem - shifted[i];
        lanes_nxt[i].quo[BIT_IDX] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.vld <= 1'b0;
    end else begin
      stg_r.vld <= stg_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    stg_r.last  <= stg_in.last;
    stg_r.lanes <= lanes_nxt;
  end

  assign stg_out = stg_r;

endmodule

`default_nettype wire

// File: hw/rtl/alpha_over_compositor_core.sv
// ============================================================================
// alpha_over_compositor_core: non-premultiplied over compositing of pixels
// Blends a draw pixel over a base pixel with exact integer quotients.
// ============================================================================
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+------------------
//  input    | in_base_c0..2, in_base_alpha, in_draw_c0..2,  | start & !busy
//           | in_draw_a, in_last                            |
//  result   | out_c0..2, out_alpha, out_last                | out_valid, 1 cycle
//
//  One item is taken every clock cycle; busy is always low.
//  The pipeline has two product stages, then eight restoring division
//  stages that each resolve one quotient bit across all four lanes.
//  Synchronous active-low reset clears only the stage valid bits.
//  The receiver cannot stall, so results leave the last stage register
//  directly as a one-cycle strobe.
// ============================================================================
`default_nettype none

module alpha_over_compositor_core (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output wire logic                     busy,
  input  wire logic [aoc_pkg::CH_W-1:0] in_base_c0,
  input  wire logic [aoc_pkg::CH_W-1:0] in_base_c1,
  input  wire logic [aoc_pkg::CH_W-1:0] in_base_c2,
  input  wire logic [aoc_pkg::CH_W-1:0] in_base_alpha,
  input  wire logic [aoc_pkg::CH_W-1:0] in_draw_c0,
  input  wire logic [aoc_pkg::CH_W-1:0] in_draw_c1,
  input  wire logic [aoc_pkg::CH_W-1:0] in_draw_c2,
  input  wire logic [aoc_pkg::CH_W-1:0] in_draw_a,
  input  wire logic                     in_last,
  output wire logic                     out_valid,
  output wire logic [aoc_pkg::CH_W-1:0] out_c0,
  output wire logic [aoc_pkg::CH_W-1:0] out_c1,
  output wire logic [aoc_pkg::CH_W-1:0] out_c2,
  output wire logic [aoc_pkg::CH_W-1:0] out_alpha,
  output wire logic                     out_last
);

  logic [aoc_pkg::CH_W-1:0] base_c [3];
  logic [aoc_pkg::CH_W-1:0] draw_c [3];
  aoc_pkg::stage_t          stg [aoc_pkg::Q_W + 1];

  // Every cycle can take an item
  assign busy = 1'b0;

  assign base_c[0] = in_base_c0;
  assign base_c[1] = in_base_c1;
  assign base_c[2] = in_base_c2;
  assign draw_c[0] = in_draw_c0;
  assign draw_c[1] = in_draw_c1;
  assign draw_c[2] = in_draw_c2;

  // Products, denominator and lane setup
  aoc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (start),
    .last_in (in_last),
    .base_c  (base_c),
    .base_a  (in_base_alpha),
    .draw_c  (draw_c),
    .draw_a  (in_draw_a),
    .stg_out (stg[0])
  );

  // Divider chain, most significant quotient bit first
  for (genvar k = 0; k < aoc_pkg::Q_W; k++) begin : g_div
    aoc_div_stage #(
      .BIT_IDX (aoc_pkg::Q_W - 1 - k)
    ) u_div_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .stg_in  (stg[k]),
      .stg_out (stg[k+1])
    );
  end

  // Drive results from the last stage register
  assign out_valid = stg[aoc_pkg::Q_W].vld;
  assign out_last  = stg[aoc_pkg::Q_W].last;
  assign out_c0    = stg[aoc_pkg::Q_W].lanes[0].quo;
  assign out_c1    = stg[aoc_pkg::Q_W].lanes[1].quo;
  assign out_c2    = stg[aoc_pkg::Q_W].lanes[2].quo;
  assign out_alpha = stg[aoc_pkg::Q_W].lanes[aoc_pkg::ALPHA_LANE].quo;

endmodule

`default_nettype wire
